FILE: sv/hist_pkg.sv
// shared types and constants for the gray image histogram
// used by hist_ctrl, hist_dp and gray_image_histogram; no dependencies
package hist_pkg;

  // field widths
  localparam int unsigned CNT_W     = 21;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PROD_W    = 2 * CFG_W;

  // default bin count
  localparam int unsigned NUM_BINS_DEF = 256;

  // largest count a bin or the pixel total can hold
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // request opcodes
  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch request and read the bin store
    logic clear;  // zero all bins and the pixel total
    logic incr;   // write back bin plus one, bump pixel total
    logic emit;   // present the read bin count
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_ok;  // latched pixel is in range and the frame is not full
  } stat_t;

endpackage

FILE: sv/hist_ctrl.sv
// request sequencer of the gray image histogram
// depends on hist_pkg for opcodes and the command and status structs
module hist_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [hist_pkg::OP_W-1:0]  opcode_i,
  input  hist_pkg::stat_t            stat_i,
  output hist_pkg::cmd_t             cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic is_read_q, is_read_d;
  logic accept;
  logic op_count;
  logic op_read;
  logic op_clear;

  // request decode
  assign accept   = start && (state_q == ST_IDLE);
  assign op_count = (opcode_i == hist_pkg::OP_COUNT);
  assign op_read  = (opcode_i == hist_pkg::OP_READ);
  assign op_clear = (opcode_i == hist_pkg::OP_CLEAR);
  assign busy     = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d     = state_q;
    is_read_d   = is_read_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_count || op_read)) begin
          cmd_o.load = 1'b1;
          is_read_d  = op_read;
          state_d    = ST_EXEC;
        end
        cmd_o.clear = accept && op_clear;
      end
      ST_EXEC: begin
        cmd_o.incr = !is_read_q && stat_i.count_ok;
        cmd_o.emit = is_read_q;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      is_read_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_read_q <= is_read_d;
    end
  end

endmodule

FILE: sv/hist_dp.sv
// datapath of the gray image histogram: size registers, frame limit,
// bin store with per-bin valid bits, pixel total and result register; uses hist_pkg
module hist_dp #(
  parameter int unsigned NUM_BINS = hist_pkg::NUM_BINS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hist_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hist_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [hist_pkg::PIX_W-1:0]      pixel_or_bin_i,
  input  hist_pkg::cmd_t                  cmd_i,
  output hist_pkg::stat_t                 stat_o,
  output logic                            done_o,
  output logic [hist_pkg::CNT_W-1:0]      bin_count_o
);

  localparam int unsigned BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic [hist_pkg::CFG_W-1:0]  width_q, height_q;
  logic [hist_pkg::PROD_W-1:0] prod;
  logic [hist_pkg::CNT_W-1:0]  limit_q, limit_d;
  logic [hist_pkg::CNT_W-1:0]  seen_q;
  logic [NUM_BINS-1:0]         valid_q;
  logic [hist_pkg::CNT_W-1:0]  mem [NUM_BINS];
  logic [BIN_W-1:0]            addr_d, addr_q;
  logic                        in_range_d, in_range_q;
  logic [hist_pkg::CNT_W-1:0]  rd_data_q;
  logic                        rd_valid_q;
  logic [hist_pkg::CNT_W-1:0]  cur_count;
  logic                        done_q;
  logic [hist_pkg::CNT_W-1:0]  bin_count_q;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == hist_pkg::REG_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_idx_i == hist_pkg::REG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // frame limit, saturated to the counter range and registered
  assign prod    = hist_pkg::PROD_W'(width_q) * hist_pkg::PROD_W'(height_q);
  assign limit_d = (prod > hist_pkg::PROD_W'(hist_pkg::CNT_MAX)) ? hist_pkg::CNT_MAX
                                                               : prod[hist_pkg::CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else begin
      limit_q <= limit_d;
    end
  end

  // bin index decode
  assign addr_d     = pixel_or_bin_i[BIN_W-1:0];
  assign in_range_d = ({1'b0, pixel_or_bin_i} < (hist_pkg::PIX_W+1)'(NUM_BINS));

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q     <= addr_d;
      in_range_q <= in_range_d;
    end
  end

  // bin store: registered read on load, write back on increment
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_data_q  <= mem[addr_d];
      rd_valid_q <= valid_q[addr_d];
    end
    if (cmd_i.incr) begin
      mem[addr_q] <= cur_count + hist_pkg::CNT_W'(1);
    end
  end

  // per-bin valid bits, an invalid bin reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (cmd_i.incr) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  assign cur_count = rd_valid_q ? rd_data_q : '0;

  // pixel total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (cmd_i.clear) begin
      seen_q <= '0;
    end else if (cmd_i.incr) begin
      seen_q <= seen_q + hist_pkg::CNT_W'(1);
    end
  end

  assign stat_o.count_ok = in_range_q && (seen_q < limit_q);

  // result register, out-of-range bins read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      bin_count_q <= in_range_q ? cur_count : '0;
    end
  end

  assign done_o      = done_q;
  assign bin_count_o = bin_count_q;

endmodule

FILE: sv/gray_image_histogram.sv
// top level of the gray image histogram
// instantiates hist_ctrl and hist_dp; uses hist_pkg
//
// Pulse start while busy is low to issue a request. During a count or read
// request, busy is high for the one cycle in which the bin store read data
// is checked and, for a count, the bin is written back. A clear request and
// the unused opcode never raise busy; clear zeroes every bin at once through
// per-bin valid bits, so no clearing pass follows reset. A read result
// appears on bin_count_o with done_o high for exactly one cycle, after the
// bin store read register and the result register; the receiver cannot
// stall it and must take it then. Size registers are written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them only while
// no request is in flight, which the block itself does not enforce. A new
// size applies to the next count and does not clear the bins.
module gray_image_histogram #(
  parameter int unsigned NUM_BINS = hist_pkg::NUM_BINS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [hist_pkg::OP_W-1:0]       opcode_i,
  input  logic [hist_pkg::PIX_W-1:0]      pixel_or_bin_i,
  output logic                            done_o,
  output logic [hist_pkg::CNT_W-1:0]      bin_count_o,
  input  logic                            cfg_we_i,
  input  logic [hist_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hist_pkg::CFG_W-1:0]      cfg_data_i
);

  hist_pkg::cmd_t  cmd;
  hist_pkg::stat_t stat;

  // request sequencer
  hist_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // bin store and counters
  hist_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_or_bin_i (pixel_or_bin_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .bin_count_o    (bin_count_o)
  );

endmodule

FILE: tb/sv/tb_gray_image_histogram.sv
// testbench for gray_image_histogram: a bin count tracker predicts every read
// result, and driver tasks issue count, read, clear and unused-opcode requests
// depends on hist_pkg and the gray_image_histogram RTL
import hist_pkg::*;

// tracks the expected histogram and checks each read result against it
class bin_count_tracker;
  logic [CNT_W-1:0] bin_tally [NUM_BINS_DEF];
  logic [CNT_W-1:0] pixel_total;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CNT_W-1:0] pending_counts [$];
  int               mismatches;

  function new();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    pixel_total  = '0;
    frame_width  = '0;
    frame_height = '0;
    mismatches   = 0;
  endfunction

  task report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    if (idx == REG_WIDTH) frame_width = val;
    else if (idx == REG_HEIGHT) frame_height = val;
  endfunction

  // frame size bounds the pixel total, saturating at the counter width
  function logic [CNT_W-1:0] frame_cap();
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(frame_width) * PROD_W'(frame_height);
    return (prod > PROD_W'(CNT_MAX)) ? CNT_MAX : prod[CNT_W-1:0];
  endfunction

  // apply one accepted request to the predicted histogram
  function void note_request(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] val);
    case (op)
      OP_COUNT: begin
        if (int'(val) < NUM_BINS_DEF && pixel_total < frame_cap()) begin
          bin_tally[val] = bin_tally[val] + 1'b1;
          pixel_total    = pixel_total + 1'b1;
        end
      end
      OP_READ: begin
        pending_counts.push_back(int'(val) < NUM_BINS_DEF ? bin_tally[val] : '0);
      end
      OP_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        pixel_total = '0;
      end
      default: ;
    endcase
  endfunction

  // compare one read result with the oldest predicted count
  task check_bin_count(input logic [CNT_W-1:0] got);
    logic [CNT_W-1:0] want;
    if (pending_counts.size() == 0) begin
      report_mismatch($sformatf("unexpected result bin_count=%0d", got));
    end else begin
      want = pending_counts.pop_front();
      if (got !== want)
        report_mismatch($sformatf("bin_count got %0d want %0d", got, want));
    end
  endtask

  function int pending();
    return pending_counts.size();
  endfunction
endclass

module tb_gray_image_histogram;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam int              DRAIN_CYCLES  = 4;
  localparam int              CYCLE_LIMIT   = 200000;
  localparam int              PHASE_ITEMS   = 75;
  localparam int              NUM_PHASES    = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      opcode_i;
  logic [PIX_W-1:0]     pixel_or_bin_i;
  logic                 done_o;
  logic [CNT_W-1:0]     bin_count_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bin_count_tracker tracker;
  int               idle_pct;
  int               cycle_cnt;

  gray_image_histogram #(
    .NUM_BINS(NUM_BINS_DEF)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .pixel_or_bin_i (pixel_or_bin_i),
    .done_o         (done_o),
    .bin_count_o    (bin_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 12 unit clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // read results are valid for one cycle only
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) tracker.check_bin_count(bin_count_o);
  end

  // issue one request, with random sender idle cycles ahead of it
  task automatic send_request(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    pixel_or_bin_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_request(op, val);
  endtask

  // wait until every read has returned and the last count has settled
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write both frame size registers back to back
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    tracker.write_reg(REG_WIDTH, w);
    cfg_idx_i  <= REG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    tracker.write_reg(REG_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // gray values cluster on a few bins half the time so reads see real counts
  function automatic logic [PIX_W-1:0] pick_value();
    return ($urandom_range(1) == 0) ? PIX_W'($urandom_range(255)) : PIX_W'($urandom_range(15));
  endfunction

  task automatic random_requests(input int n);
    int               sent;
    int               r;
    logic [OP_W-1:0]  op;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 55) op = OP_COUNT;
      else if (r < 85) op = OP_READ;
      else if (r < 93) op = OP_CLEAR;
      else op = OP_UNUSED;
      send_request(op, pick_value());
      if (op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    int phase_idle [NUM_PHASES];
    tracker        = new();
    idle_pct       = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    opcode_i       = OP_COUNT;
    pixel_or_bin_i = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_WIDTH;
    cfg_data_i     = '0;
    phase_idle     = '{0, 56, 15, 0, 56, 15};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero frame size out of reset: nothing is counted
    send_request(OP_COUNT, 8'd5);
    send_request(OP_READ, 8'd5);
    drain();

    // 3x2 frame fills after six pixels, top and bottom values included
    set_frame(11'd3, 11'd2);
    send_request(OP_COUNT, 8'd0);
    send_request(OP_COUNT, 8'd255);
    send_request(OP_COUNT, 8'd255);
    send_request(OP_COUNT, 8'd128);
    send_request(OP_COUNT, 8'd1);
    send_request(OP_COUNT, 8'd254);
    send_request(OP_COUNT, 8'd255);
    send_request(OP_READ, 8'd255);
    send_request(OP_READ, 8'd0);
    send_request(OP_UNUSED, 8'd255);
    drain();

    // growing the frame mid-way lets counting resume without a clear
    set_frame(11'd3, 11'd3);
    send_request(OP_COUNT, 8'd255);
    send_request(OP_READ, 8'd255);
    drain();

    // shrinking below the pixel total blocks counting until a clear
    set_frame(11'd1, 11'd1);
    send_request(OP_COUNT, 8'd0);
    send_request(OP_READ, 8'd0);
    send_request(OP_CLEAR, 8'd0);
    send_request(OP_READ, 8'd255);
    send_request(OP_COUNT, 8'd255);
    send_request(OP_COUNT, 8'd0);
    send_request(OP_READ, 8'd255);
    drain();

    // largest register values: frame limit saturates
    set_frame(11'h7FF, 11'h7FF);
    send_request(OP_COUNT, 8'hAA);
    send_request(OP_COUNT, 8'h55);
    send_request(OP_READ, 8'hAA);
    send_request(OP_READ, 8'h55);
    drain();

    // random phases with varying frame sizes and sender idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_frame(11'h7FF, 11'h7FF);
        2: set_frame(11'd0, CFG_W'($urandom_range(1, 2047)));
        4: set_frame(11'd1024, 11'd1024);
        default: set_frame(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)));
      endcase
      idle_pct = phase_idle[p];
      random_requests(PHASE_ITEMS);
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: gray_image_histogram.f
sv/hist_pkg.sv
sv/hist_ctrl.sv
sv/hist_dp.sv
sv/gray_image_histogram.sv
tb/sv/tb_gray_image_histogram.sv
